/* src/rics_pkg.sv */
// Shared types, field widths, parameter defaults and action codes of the inode slot cache.
`timescale 1ns / 1ps

package rics_pkg;

    // Parameter defaults handed to the top level.
    localparam int SLOTS_DEFAULT       = 32;
    localparam int NUMBER_BITS_DEFAULT = 16;
    localparam int REF_BITS_DEFAULT    = 8;

    // Fixed widths of the transfer fields.
    localparam int ACTION_W = 2;
    localparam int INODE_W  = 16;
    localparam int SLOT_W   = 5;
    localparam int COUNT_W  = 8;

    // Action codes.
    localparam logic [ACTION_W-1:0] ACT_ACQUIRE   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_DUPLICATE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_RELEASE   = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_LOCK      = 2'd3;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [INODE_W-1:0]  inode_number;
        logic [SLOT_W-1:0]   slot_index;
        logic                no_links;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0]  result_slot;
        logic               hit;
        logic               table_full;
        logic               destroy;
        logic               needs_load;
        logic [COUNT_W-1:0] ref_count;
    } t_rsp;

endpackage

/* src/rics_stream_if.sv */
// Valid/ready stream interface that carries one payload per transfer.
`timescale 1ns / 1ps

interface rics_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* src/refcounted_inode_slot_cache.sv */
// Top level of the reference-counted inode slot cache.
`timescale 1ns / 1ps

// Reference-counted inode slot cache. Each slot holds an inode number, a
// reference count and a valid mark, all kept in one word of a single RAM with
// a registered read. Requests arrive as transfers on i_req and every request
// yields exactly one response transfer on o_rsp. Only one request is worked
// on at a time. Duplicate, release and lock read the addressed slot, update
// it and write it back; release and lock leave a free slot as it is, and an
// index beyond the table changes nothing. The slot is read in S_READ and the
// response is registered in S_FINISH. Acquire sweeps the slots in order
// through the one RAM read port, one slot per cycle; a hit ends the sweep at
// the lowest slot in use with the number. A miss claims the lowest free slot,
// or reports a full table, once the last slot has been read. A new request
// is taken while the previous response still waits in the output register;
// when the following response is done too, the sequencer holds it until the
// output register frees up, and the input stalls meanwhile. There is no
// clearing pass after reset: a per-slot written bit, cleared by reset, makes
// a slot that was never written read as number zero, count zero and not valid.
module refcounted_inode_slot_cache #(
    parameter int SLOTS       = rics_pkg::SLOTS_DEFAULT,
    parameter int NUMBER_BITS = rics_pkg::NUMBER_BITS_DEFAULT,
    parameter int REF_BITS    = rics_pkg::REF_BITS_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rics_stream_if.sink   i_req,
    rics_stream_if.source o_rsp
);

    localparam int AW = $clog2(SLOTS);
    localparam int WW = NUMBER_BITS + REF_BITS + 1;
    localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};
    localparam logic [REF_BITS-1:0] REF_ONE = REF_BITS'(1);
    localparam logic [AW-1:0]       LAST    = AW'(SLOTS - 1);

    // Sequencer states.
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_READ   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    // Control registers.
    logic [1:0]       r_state,   n_state;
    logic             r_out_valid;
    logic [SLOTS-1:0] r_written;

    // Latched request.
    logic [NUMBER_BITS-1:0]        r_num;
    logic [rics_pkg::ACTION_W-1:0] r_action;
    logic [rics_pkg::SLOT_W-1:0]   r_slot;
    logic                          r_unlinked;

    // Sweep bookkeeping for acquire.
    logic [AW-1:0] r_scan,      n_scan;
    logic          r_have_free, n_have_free;
    logic [AW-1:0] r_free,      n_free;

    // Pending write-back and pending response.
    logic                        r_wr_en,     n_wr_en;
    logic [AW-1:0]               r_wr_addr,   n_wr_addr;
    logic [WW-1:0]               r_wr_data,   n_wr_data;
    logic [rics_pkg::SLOT_W-1:0] r_res_slot,  n_res_slot;
    logic                        r_res_hit,   n_res_hit;
    logic                        r_res_full,  n_res_full;
    logic                        r_res_dstr,  n_res_dstr;
    logic                        r_res_load,  n_res_load;
    logic [REF_BITS-1:0]         r_res_refs,  n_res_refs;

    rics_pkg::t_rsp r_out;

    // Request decode.
    logic                   w_accept;
    logic [31:0]            w_in_num32;
    logic [NUMBER_BITS-1:0] w_in_num;
    logic [8:0]             w_in_idx9;
    logic                   w_in_range;
    logic [AW-1:0]          w_in_addr;
    logic [8:0]             w_slot9;
    logic [AW-1:0]          w_idx_addr;

    // RAM access and entry decode.
    logic [AW-1:0]          w_rd_addr;
    logic [WW-1:0]          w_rd_data;
    logic                   w_ram_we;
    logic [AW-1:0]          w_cur_addr;
    logic [WW-1:0]          w_ent;
    logic [NUMBER_BITS-1:0] w_ent_num;
    logic [REF_BITS-1:0]    w_ent_refs;
    logic                   w_ent_valid;
    logic [REF_BITS-1:0]    w_refs_inc;
    logic [REF_BITS-1:0]    w_refs_dec;
    logic                   w_match;
    logic                   w_cur_free;
    logic                   w_any_free;
    logic [AW-1:0]          w_first_free;
    logic [8:0]             w_scan9;
    logic [8:0]             w_free9;
    logic                   w_destroy;
    logic                   w_out_free;
    logic [31:0]            w_res_refs32;

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_out_free = !r_out_valid || o_rsp.ready;

    // Only the low NUMBER_BITS bits of the inode number take part.
    assign w_in_num32 = 32'(i_req.data.inode_number);
    assign w_in_num   = w_in_num32[NUMBER_BITS-1:0];
    assign w_in_idx9  = 9'(i_req.data.slot_index);
    assign w_in_range = w_in_idx9 < 9'(SLOTS);
    assign w_in_addr  = w_in_idx9[AW-1:0];
    assign w_slot9    = 9'(r_slot);
    assign w_idx_addr = w_slot9[AW-1:0];

    rics_ram #(
        .WIDTH (WW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_we),
        .i_wr_addr (r_wr_addr),
        .i_wr_data (r_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_ram_we = (r_state == S_FINISH) && w_out_free && r_wr_en;

    // A slot that was never written reads as its reset value.
    assign w_cur_addr  = (r_state == S_SCAN) ? r_scan : w_idx_addr;
    assign w_ent       = r_written[w_cur_addr] ? w_rd_data : '0;
    assign w_ent_num   = w_ent[NUMBER_BITS-1:0];
    assign w_ent_refs  = w_ent[NUMBER_BITS +: REF_BITS];
    assign w_ent_valid = w_ent[WW-1];

    // Counts saturate at the top; decrement is only used on a nonzero count.
    assign w_refs_inc = (w_ent_refs == REF_MAX) ? w_ent_refs : w_ent_refs + REF_ONE;
    assign w_refs_dec = w_ent_refs - REF_ONE;

    assign w_match      = (w_ent_refs != '0) && (w_ent_num == r_num);
    assign w_cur_free   = (w_ent_refs == '0);
    assign w_any_free   = r_have_free || w_cur_free;
    assign w_first_free = r_have_free ? r_free : r_scan;
    assign w_scan9      = 9'(r_scan);
    assign w_free9      = 9'(w_first_free);
    assign w_destroy    = (w_ent_refs == REF_ONE) && w_ent_valid && r_unlinked;
    assign w_res_refs32 = 32'(r_res_refs);

    always_comb begin
        n_state     = r_state;
        n_scan      = r_scan;
        n_have_free = r_have_free;
        n_free      = r_free;
        n_wr_en     = r_wr_en;
        n_wr_addr   = r_wr_addr;
        n_wr_data   = r_wr_data;
        n_res_slot  = r_res_slot;
        n_res_hit   = r_res_hit;
        n_res_full  = r_res_full;
        n_res_dstr  = r_res_dstr;
        n_res_load  = r_res_load;
        n_res_refs  = r_res_refs;
        w_rd_addr   = '0;

        case (r_state)
            S_IDLE: begin
                if (i_req.data.action == rics_pkg::ACT_ACQUIRE) begin
                    w_rd_addr = '0;
                end else begin
                    w_rd_addr = w_in_addr;
                end
                if (w_accept) begin
                    if (i_req.data.action == rics_pkg::ACT_ACQUIRE) begin
                        n_scan      = '0;
                        n_have_free = 1'b0;
                        n_state     = S_SCAN;
                    end else if (!w_in_range) begin
                        // Slot beyond the table: nothing changes.
                        n_wr_en    = 1'b0;
                        n_res_slot = i_req.data.slot_index;
                        n_res_hit  = 1'b0;
                        n_res_full = 1'b0;
                        n_res_dstr = 1'b0;
                        n_res_load = 1'b0;
                        n_res_refs = '0;
                        n_state    = S_FINISH;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end

            S_SCAN: begin
                n_res_hit  = 1'b0;
                n_res_full = 1'b0;
                n_res_dstr = 1'b0;
                n_res_load = 1'b0;
                w_rd_addr  = r_scan + AW'(1);
                if (w_match) begin
                    // The lowest slot in use with this number wins.
                    n_wr_en    = 1'b1;
                    n_wr_addr  = r_scan;
                    n_wr_data  = {w_ent_valid, w_refs_inc, w_ent_num};
                    n_res_slot = w_scan9[rics_pkg::SLOT_W-1:0];
                    n_res_hit  = 1'b1;
                    n_res_refs = w_refs_inc;
                    n_state    = S_FINISH;
                end else if (r_scan == LAST) begin
                    if (w_any_free) begin
                        // Claim the lowest free slot, not yet loaded.
                        n_wr_en    = 1'b1;
                        n_wr_addr  = w_first_free;
                        n_wr_data  = {1'b0, REF_ONE, r_num};
                        n_res_slot = w_free9[rics_pkg::SLOT_W-1:0];
                        n_res_refs = REF_ONE;
                    end else begin
                        n_wr_en    = 1'b0;
                        n_res_slot = '0;
                        n_res_full = 1'b1;
                        n_res_refs = '0;
                    end
                    n_state = S_FINISH;
                end else begin
                    n_scan = r_scan + AW'(1);
                    if (!r_have_free && w_cur_free) begin
                        n_have_free = 1'b1;
                        n_free      = r_scan;
                    end
                end
            end

            S_READ: begin
                n_wr_addr  = w_idx_addr;
                n_res_slot = r_slot;
                n_res_hit  = 1'b0;
                n_res_full = 1'b0;
                n_res_dstr = 1'b0;
                n_res_load = 1'b0;
                n_res_refs = w_ent_refs;
                n_wr_en    = 1'b0;
                n_wr_data  = w_ent;
                case (r_action)
                    rics_pkg::ACT_DUPLICATE: begin
                        // A free slot comes back into use with its old contents.
                        n_wr_en    = 1'b1;
                        n_wr_data  = {w_ent_valid, w_refs_inc, w_ent_num};
                        n_res_refs = w_refs_inc;
                    end
                    rics_pkg::ACT_RELEASE: begin
                        if (w_ent_refs != '0) begin
                            n_wr_en    = 1'b1;
                            n_wr_data  = {w_ent_valid && !w_destroy, w_refs_dec, w_ent_num};
                            n_res_refs = w_refs_dec;
                            n_res_dstr = w_destroy;
                        end
                    end
                    rics_pkg::ACT_LOCK: begin
                        if (w_ent_refs != '0) begin
                            n_wr_en    = 1'b1;
                            n_wr_data  = {1'b1, w_ent_refs, w_ent_num};
                            n_res_load = !w_ent_valid;
                        end
                    end
                    default: begin
                        n_wr_en = 1'b0;
                    end
                endcase
                n_state = S_FINISH;
            end

            S_FINISH: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_written   <= '0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_FINISH) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_ram_we) begin
                r_written[r_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_num      <= w_in_num;
            r_action   <= i_req.data.action;
            r_slot     <= i_req.data.slot_index;
            r_unlinked <= i_req.data.no_links;
        end
        r_scan      <= n_scan;
        r_have_free <= n_have_free;
        r_free      <= n_free;
        r_wr_en     <= n_wr_en;
        r_wr_addr   <= n_wr_addr;
        r_wr_data   <= n_wr_data;
        r_res_slot  <= n_res_slot;
        r_res_hit   <= n_res_hit;
        r_res_full  <= n_res_full;
        r_res_dstr  <= n_res_dstr;
        r_res_load  <= n_res_load;
        r_res_refs  <= n_res_refs;
        if ((r_state == S_FINISH) && w_out_free) begin
            r_out.result_slot <= r_res_slot;
            r_out.hit         <= r_res_hit;
            r_out.table_full  <= r_res_full;
            r_out.destroy     <= r_res_dstr;
            r_out.needs_load  <= r_res_load;
            r_out.ref_count   <= w_res_refs32[rics_pkg::COUNT_W-1:0];
        end
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

endmodule

/* src/rics_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps

module rics_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* tb/tb.sv */
// Self-checking testbench for the reference-counted inode slot cache.
`timescale 1ns / 1ps

// Requests go into the cache one transfer at a time. Each accepted request is
// run through a shadow copy of the slot table, and the response it should
// produce is queued. Every response transfer is checked field by field against
// the oldest queued response. The directed tests cover the reset state, the
// table running full and count saturation. The pressure test lets requests
// pile up behind a stalled response port. The random test then runs
// acquire/lock/duplicate/release lifecycles mixed with arbitrary requests.
module tb;

    localparam int          SLOTS       = rics_pkg::SLOTS_DEFAULT;
    localparam int          ACTION_W    = rics_pkg::ACTION_W;
    localparam int          INODE_W     = rics_pkg::INODE_W;
    localparam int          SLOT_W      = rics_pkg::SLOT_W;
    localparam logic [7:0]  COUNT_MAX   = 8'hFF;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          DRAIN_WAIT  = SLOTS + 8;

    logic i_clk;
    logic i_rst_n;

    rics_stream_if #(.T(rics_pkg::t_req)) req_if ();
    rics_stream_if #(.T(rics_pkg::t_rsp)) rsp_if ();

    refcounted_inode_slot_cache u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // Shadow copy of the slot table.
    logic [15:0] shadow_number [SLOTS];
    logic [7:0]  shadow_refs   [SLOTS];
    logic        shadow_valid  [SLOTS];

    rics_pkg::t_rsp pending_rsps [$];
    int   mismatch_count = 0;
    bit   idle_on = 1'b0;
    int   hold_req = 0;
    int   cycle_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Works out the response to one request and updates the shadow table.
    function automatic rics_pkg::t_rsp predict_cache_rsp(input rics_pkg::t_req r);
        rics_pkg::t_rsp p;
        bit   found;
        bit   have_free;
        int   hit_slot;
        int   free_slot;
        int   s;
        p = '0;
        p.result_slot = r.slot_index;
        s = r.slot_index;
        case (r.action)
            rics_pkg::ACT_ACQUIRE: begin
                found = 1'b0;
                have_free = 1'b0;
                hit_slot = 0;
                free_slot = 0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (!found && shadow_refs[i] != 0 && shadow_number[i] == r.inode_number) begin
                        found = 1'b1;
                        hit_slot = i;
                    end
                    if (!have_free && shadow_refs[i] == 0) begin
                        have_free = 1'b1;
                        free_slot = i;
                    end
                end
                if (found) begin
                    if (shadow_refs[hit_slot] != COUNT_MAX)
                        shadow_refs[hit_slot]++;
                    p.result_slot = hit_slot[SLOT_W-1:0];
                    p.hit = 1'b1;
                    p.ref_count = shadow_refs[hit_slot];
                end else if (!have_free) begin
                    p.result_slot = '0;
                    p.table_full = 1'b1;
                end else begin
                    shadow_number[free_slot] = r.inode_number;
                    shadow_refs[free_slot] = 8'd1;
                    shadow_valid[free_slot] = 1'b0;
                    p.result_slot = free_slot[SLOT_W-1:0];
                    p.ref_count = 8'd1;
                end
            end
            rics_pkg::ACT_DUPLICATE: begin
                if (shadow_refs[s] != COUNT_MAX)
                    shadow_refs[s]++;
                p.ref_count = shadow_refs[s];
            end
            rics_pkg::ACT_RELEASE: begin
                if (shadow_refs[s] != 0) begin
                    // Dropping the last reference of a loaded, unlinked inode frees it.
                    if (shadow_refs[s] == 1 && shadow_valid[s] && r.no_links) begin
                        p.destroy = 1'b1;
                        shadow_valid[s] = 1'b0;
                    end
                    shadow_refs[s]--;
                end
                p.ref_count = shadow_refs[s];
            end
            default: begin
                // Lock of a free slot is ignored.
                if (shadow_refs[s] != 0) begin
                    p.needs_load = !shadow_valid[s];
                    shadow_valid[s] = 1'b1;
                end
                p.ref_count = shadow_refs[s];
            end
        endcase
        return p;
    endfunction

    function automatic rics_pkg::t_req make_req(input logic [ACTION_W-1:0] action,
                                                input logic [INODE_W-1:0] number,
                                                input logic [SLOT_W-1:0] slot,
                                                input logic no_links);
        rics_pkg::t_req r;
        r.action = action;
        r.inode_number = number;
        r.slot_index = slot;
        r.no_links = no_links;
        return r;
    endfunction

    function automatic rics_pkg::t_req random_req();
        return make_req(ACTION_W'($urandom), INODE_W'($urandom), SLOT_W'($urandom),
                        1'($urandom));
    endfunction

    // Offers one request and waits for its transfer. Valid stays high when the
    // next request follows without a gap, so it is never dropped and raised in
    // the same time step.
    task automatic issue(input rics_pkg::t_req r, output rics_pkg::t_rsp pred);
        int gap;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= r;
        do @(posedge i_clk); while (!req_if.ready);
        pred = predict_cache_rsp(r);
        pending_rsps.push_back(pred);
    endtask

    task automatic wait_for_drain();
        req_if.valid <= 1'b0;
        while (pending_rsps.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic check_rsp(input rics_pkg::t_rsp got);
        rics_pkg::t_rsp want;
        if (pending_rsps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected response: %p", got);
        end else begin
            want = pending_rsps.pop_front();
            if (got.result_slot !== want.result_slot || got.hit !== want.hit ||
                got.table_full !== want.table_full || got.destroy !== want.destroy ||
                got.needs_load !== want.needs_load || got.ref_count !== want.ref_count) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("response mismatch: expected %p, got %p", want, got);
            end
        end
    endtask

    // Response side: checks each transfer and stalls a random number of cycles
    // before taking the next one. A long hold-off can be requested by a test.
    initial begin : rsp_side
        int wait_left;
        int hold_left;
        wait_left = 0;
        hold_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
                check_rsp(rsp_if.data);
                wait_left = idle_on ? $urandom_range(0, 9) : 0;
            end
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req <= 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end else if (wait_left > 0) begin
                wait_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("refcounted_inode_slot_cache regression: fail");
        $finish;
    end

    // Free slots, stale numbers, hits, loads, destroys and ignored requests.
    task automatic test_slot_lifecycle();
        rics_pkg::t_rsp p;
        idle_on = 1'b1;
        issue(make_req(rics_pkg::ACT_LOCK,      16'h0000, 5'd0,  1'b1), p);
        issue(make_req(rics_pkg::ACT_RELEASE,   16'hFFFF, 5'd31, 1'b1), p);
        issue(make_req(rics_pkg::ACT_ACQUIRE,   16'h0000, 5'd31, 1'b0), p);
        issue(make_req(rics_pkg::ACT_ACQUIRE,   16'hFFFF, 5'd0,  1'b1), p);
        issue(make_req(rics_pkg::ACT_ACQUIRE,   16'h0000, 5'd0,  1'b0), p);
        issue(make_req(rics_pkg::ACT_LOCK,      16'h0000, 5'd0,  1'b0), p);
        issue(make_req(rics_pkg::ACT_LOCK,      16'h0000, 5'd0,  1'b0), p);
        issue(make_req(rics_pkg::ACT_DUPLICATE, 16'h0000, 5'd1,  1'b0), p);
        issue(make_req(rics_pkg::ACT_RELEASE,   16'h0000, 5'd0,  1'b1), p);
        issue(make_req(rics_pkg::ACT_RELEASE,   16'h0000, 5'd0,  1'b1), p);
        issue(make_req(rics_pkg::ACT_RELEASE,   16'h0000, 5'd1,  1'b1), p);
        issue(make_req(rics_pkg::ACT_LOCK,      16'h0000, 5'd1,  1'b1), p);
        issue(make_req(rics_pkg::ACT_RELEASE,   16'h0000, 5'd1,  1'b0), p);
        // A duplicate brings a free slot back with its stale number.
        issue(make_req(rics_pkg::ACT_DUPLICATE, 16'h0000, 5'd31, 1'b0), p);
        issue(make_req(rics_pkg::ACT_DUPLICATE, 16'h0000, 5'd5,  1'b0), p);
        issue(make_req(rics_pkg::ACT_ACQUIRE,   16'h0000, 5'd0,  1'b0), p);
        issue(make_req(rics_pkg::ACT_RELEASE,   16'h0000, 5'd5,  1'b1), p);
        issue(make_req(rics_pkg::ACT_RELEASE,   16'h0000, 5'd5,  1'b1), p);
        // Slot 1 is free and still holds 0xFFFF, so this must miss.
        issue(make_req(rics_pkg::ACT_ACQUIRE,   16'hFFFF, 5'd0,  1'b0), p);
        issue(make_req(rics_pkg::ACT_LOCK,      16'h0000, 5'd31, 1'b0), p);
        issue(make_req(rics_pkg::ACT_RELEASE,   16'h0000, 5'd31, 1'b1), p);
    endtask

    // Fill every slot, miss on a full table, then release everything.
    task automatic test_table_full();
        rics_pkg::t_rsp p;
        int   k;
        idle_on = 1'b1;
        k = 0;
        do begin
            issue(make_req(rics_pkg::ACT_ACQUIRE, 16'h4000 + k[15:0], SLOT_W'($urandom),
                           1'b0), p);
            k++;
        end while (!p.table_full && k < 2 * SLOTS);
        issue(make_req(rics_pkg::ACT_ACQUIRE, 16'h7777, 5'd3, 1'b1), p);
        issue(make_req(rics_pkg::ACT_ACQUIRE, 16'h4000, 5'd0, 1'b0), p);
        for (int i = 0; i < SLOTS; i++) begin
            if (i % 3 != 2)
                issue(make_req(rics_pkg::ACT_LOCK, 16'h0000, i[SLOT_W-1:0], 1'b0), p);
            while (shadow_refs[i] != 0)
                issue(make_req(rics_pkg::ACT_RELEASE, 16'h0000, i[SLOT_W-1:0],
                               1'($urandom)), p);
        end
    endtask

    // Drive one slot's count up to its ceiling and past it.
    task automatic test_count_saturation();
        rics_pkg::t_rsp    p;
        logic [SLOT_W-1:0] s;
        idle_on = 1'b0;
        issue(make_req(rics_pkg::ACT_ACQUIRE, 16'hA5A5, 5'd0, 1'b0), p);
        s = p.result_slot;
        repeat (256) issue(make_req(rics_pkg::ACT_DUPLICATE, 16'h0000, s, 1'b0), p);
        issue(make_req(rics_pkg::ACT_ACQUIRE, 16'hA5A5, 5'd0, 1'b0), p);
        repeat (3) issue(make_req(rics_pkg::ACT_RELEASE, 16'h0000, s, 1'b1), p);
    endtask

    // Hold the response port while requests keep coming, so the input stalls.
    task automatic test_output_stall();
        rics_pkg::t_rsp p;
        idle_on = 1'b0;
        hold_req <= 120;
        repeat (12) issue(random_req(), p);
        wait_for_drain();
    endtask

    function automatic logic [15:0] pick_number(input logic [15:0] pool [12]);
        if ($urandom_range(0, 3) != 0)
            return pool[$urandom_range(0, 11)];
        return 16'($urandom);
    endfunction

    // Mostly whole lifecycles on a small set of numbers, with arbitrary
    // requests mixed in.
    task automatic test_random_traffic();
        logic [15:0]       pool [12];
        rics_pkg::t_rsp    p;
        logic [SLOT_W-1:0] s;
        int                sent;
        int                dups;
        int                rels;
        pool[0] = 16'h0000;
        pool[1] = 16'hFFFF;
        for (int i = 2; i < 12; i++)
            pool[i] = 16'($urandom);
        sent = 0;
        idle_on = 1'b1;
        while (sent < 300) begin
            if ($urandom_range(0, 11) == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 7) begin
                issue(make_req(rics_pkg::ACT_ACQUIRE, pick_number(pool), SLOT_W'($urandom),
                               1'($urandom)), p);
                sent++;
                if (!p.table_full) begin
                    s = p.result_slot;
                    if ($urandom_range(0, 3) != 0) begin
                        issue(make_req(rics_pkg::ACT_LOCK, 16'($urandom), s, 1'($urandom)), p);
                        sent++;
                    end
                    dups = $urandom_range(0, 2);
                    repeat (dups) begin
                        issue(make_req(rics_pkg::ACT_DUPLICATE, 16'($urandom), s,
                                       1'($urandom)), p);
                        sent++;
                    end
                    rels = ($urandom_range(0, 3) != 0) ? dups + 1 : $urandom_range(0, dups);
                    repeat (rels) begin
                        issue(make_req(rics_pkg::ACT_RELEASE, 16'($urandom), s,
                                       1'($urandom)), p);
                        sent++;
                    end
                end
            end else begin
                issue(random_req(), p);
                sent++;
            end
        end
    endtask

    initial begin : stimulus
        for (int i = 0; i < SLOTS; i++) begin
            shadow_number[i] = '0;
            shadow_refs[i] = '0;
            shadow_valid[i] = 1'b0;
        end
        i_rst_n      <= 1'b0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_slot_lifecycle();
        test_table_full();
        test_count_saturation();
        test_output_stall();
        test_random_traffic();
        wait_for_drain();

        if (mismatch_count == 0)
            $display("refcounted_inode_slot_cache regression: pass");
        else
            $display("refcounted_inode_slot_cache regression: fail");
        $finish;
    end
endmodule
